@@ src/esd_pkg.sv @@
// Shared types, constants and register codes of the encoder speed decimator.
package esd_pkg;

  // Default channel count and the number of channels with a gain register.
  localparam int CHANNELS_DEF = 4;
  localparam int NUM_GAINS    = 4;

  // Item operations.
  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Average kinds reported with each result.
  localparam logic [1:0] AVG_NONE = 2'd0;
  localparam logic [1:0] AVG_NEW  = 2'd1;
  localparam logic [1:0] AVG_IDLE = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TICKS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH0    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH2    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH3    = 3'd5;

  // Register reset values.
  localparam logic [15:0]        SAMPLES_LEN_RST = 16'd10;
  localparam logic [15:0]        IDLE_TICKS_RST  = 16'd1;
  localparam logic signed [31:0] GAIN_CH0_RST    = 32'sd262144;
  localparam logic signed [31:0] GAIN_ONE        = 32'sd65536;

  // Speed scaling: 1e6 microseconds per second, times 256 for Q.8.
  localparam logic [27:0] SCALE_US_Q8 = 28'd256000000;
  localparam int          PROD_W      = 60;

  // Saturation bounds.
  localparam logic signed [47:0] SPEED_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SPEED_MIN = 48'sh8000_0000_0000;
  localparam logic signed [63:0] SUM_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SUM_MIN   = 64'sh8000_0000_0000_0000;
  localparam logic [15:0]        CNT_MAX   = 16'hFFFF;

  // Divider geometry: 64-bit dividend, 24-bit divisor, two quotient bits a cycle.
  localparam int DVD_W          = 64;
  localparam int DVS_W          = 24;
  localparam int DIV_RADIX_BITS = 2;

  // Multiplier geometry: 64-bit magnitude by 32-bit gain magnitude.
  localparam int MUL_FULL_W = 96;
  localparam int Q8_SHIFT   = 8;

  // Per-channel state held in the channel memory.
  typedef struct packed {
    logic signed [31:0] count_pos;
    logic signed [47:0] inst_speed;
    logic signed [63:0] speed_sum;
    logic [15:0]        sample_count;
    logic               updated;
    logic [15:0]        idle_count;
  } ch_entry_t;

  // Divider request and response.
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  // Saturating Q.8 multiplier request and response.
  typedef struct packed {
    logic               start;
    logic               a_neg;
    logic [63:0]        mag;
    logic signed [31:0] gain;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] value;
  } mul_rsp_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EV_RD,
    ST_EV_START,
    ST_EV_DIV,
    ST_EV_SPD,
    ST_EV_WB,
    ST_TK_RD,
    ST_TK_POS,
    ST_TK_VEL,
    ST_TK_DIVS,
    ST_TK_DIV,
    ST_TK_AMUL,
    ST_TK_AWAIT,
    ST_TK_OUT
  } state_t;

endpackage

@@ src/esd_if.sv @@
// Valid/ready channel interfaces for event/tick items and result items.
interface esd_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [1:0]         channel;
  logic signed [31:0] position;
  logic signed [31:0] position_change;
  logic [23:0]        interval_us;

  modport source (output valid, op, channel, position, position_change, interval_us,
                  input ready);
  modport sink   (input valid, op, channel, position, position_change, interval_us,
                  output ready);
endinterface

interface esd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         out_channel;
  logic signed [63:0] position_rad;
  logic signed [63:0] velocity_rad;
  logic [1:0]         avg_kind;
  logic signed [63:0] avg_speed;
  logic               last;

  modport source (output valid, out_channel, position_rad, velocity_rad, avg_kind,
                  avg_speed, last, input ready);
  modport sink   (input valid, out_channel, position_rad, velocity_rad, avg_kind,
                  avg_speed, last, output ready);
endinterface

@@ src/esd_mem.sv @@
// Per-channel state memory with a registered read port and per-entry valid bits.
module esd_mem
  import esd_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rd_en,
  input  logic [CH_W-1:0] rd_addr,
  output ch_entry_t       rd_data,
  input  logic            wr_en,
  input  logic [CH_W-1:0] wr_addr,
  input  ch_entry_t       wr_data
);

  ch_entry_t             mem_r [CHANNELS];
  logic [CHANNELS-1:0]   valid_r;
  ch_entry_t             rd_data_r;

  // Storage array write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // An entry never written since reset reads as all zeros.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem_r[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/esd_div.sv @@
// Unsigned restoring divider, two quotient bits per cycle.
module esd_div
  import esd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEPS  = DVD_W / DIV_RADIX_BITS;
  localparam int STEP_W = $clog2(STEPS);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  rem_nxt;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVD_W-1:0]  work_r;
  logic [DVD_W-1:0]  work_nxt;

  // Two dependent shift-subtract steps; quotient bits shift in behind the dividend.
  always_comb begin
    logic [DVS_W:0] t;
    rem_nxt  = rem_r;
    work_nxt = work_r;
    t        = '0;
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      t        = {rem_nxt, work_nxt[DVD_W-1]};
      work_nxt = {work_nxt[DVD_W-2:0], 1'b0};
      if (t >= {1'b0, dvs_r}) begin
        rem_nxt     = DVS_W'(t - {1'b0, dvs_r});
        work_nxt[0] = 1'b1;
      end else begin
        rem_nxt = t[DVS_W-1:0];
      end
    end
  end

  // Step control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= '0;
      work_r <= req.dividend;
      dvs_r  <= req.divisor;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      work_r <= work_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = work_r;

endmodule

@@ src/esd_mul.sv @@
// Sign-magnitude (a * gain) >> 8 with truncation toward zero and 64-bit saturation.
module esd_mul
  import esd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic                    busy_r;
  logic                    done_r;
  logic [1:0]              phase_r;
  logic                    neg_r;
  logic [63:0]             m_r;
  logic [31:0]             gm_r;
  logic [63:0]             plo_r;
  logic [63:0]             phi_r;
  logic [MUL_FULL_W-1:0]   p_r;
  logic signed [63:0]      value_r;
  logic signed [63:0]      value_nxt;
  logic [MUL_FULL_W-Q8_SHIFT-1:0] shifted;
  logic [63:0]             lim;
  logic [63:0]             mag_sat;

  // Drop the Q.8 fraction, clamp the magnitude, then apply the sign.
  always_comb begin
    shifted   = p_r[MUL_FULL_W-1:Q8_SHIFT];
    lim       = neg_r ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    mag_sat   = ((|shifted[MUL_FULL_W-Q8_SHIFT-1:64]) || (shifted[63:0] > lim)) ?
                lim : shifted[63:0];
    value_nxt = neg_r ? $signed(~mag_sat + 64'd1) : $signed(mag_sat);
  end

  // Phase control: low partial, high partial, accumulate, saturate.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r  <= 1'b1;
        phase_r <= '0;
      end else if (busy_r) begin
        phase_r <= phase_r + 1'b1;
        if (phase_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath, one 32x32 product per cycle.
  always_ff @(posedge clk) begin
    if (req.start) begin
      m_r   <= req.mag;
      gm_r  <= req.gain[31] ? (~req.gain + 32'd1) : req.gain;
      neg_r <= req.a_neg ^ req.gain[31];
    end else if (busy_r) begin
      case (phase_r)
        2'd0: plo_r <= 64'(m_r[31:0]) * 64'(gm_r);
        2'd1: phi_r <= 64'(m_r[63:32]) * 64'(gm_r);
        2'd2: p_r   <= MUL_FULL_W'(plo_r) + {phi_r, 32'd0};
        2'd3: value_r <= value_nxt;
        default: ;
      endcase
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = value_r;

endmodule

@@ src/encoder_speed_decimator.sv @@
// Top level of the per-channel encoder speed estimator with decimated averaging.
//
//   Port      Dir  Handshake      Carries
//   in_bus    in   valid/ready    event or tick item (op, channel, counts, interval)
//   out_bus   out  valid/ready    one result item per channel on a tick
//   cfg_*     in   write enable   samples_len, idle_ticks, gain_ch0..gain_ch3
//
// An event reads its entry and divides the scaled change by the interval in the
// two-bit-per-cycle divider, then saturates the speed and writes the entry back.
// A tick visits each channel; a new average adds a divide and a second multiply.
// Reset clears the channel memory's valid bits; there is no sweep.
// A stalled result holds the sequencer in its output step; a new item is taken
// only when the previous one is done, while a final result may still be waiting.
module encoder_speed_decimator
  import esd_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  esd_in_if.sink               in_bus,
  esd_out_if.source            out_bus,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]          cfg_wdata
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [15:0]        samples_len_r;
  logic [15:0]        idle_ticks_r;
  logic signed [31:0] gain_r [NUM_GAINS];

  // Latched item and working registers.
  logic [1:0]          ch_r;
  logic signed [31:0]  pos_r;
  logic signed [31:0]  chg_r;
  logic [23:0]         iv_r;
  logic [PROD_W-1:0]   prod_r;
  logic signed [47:0]  sp_r;
  logic signed [47:0]  sp_nxt;
  logic [CH_W-1:0]     cnt_r;
  logic signed [63:0]  pos_rad_r;
  logic signed [63:0]  vel_r;
  logic signed [63:0]  avg_r;

  // Output register.
  logic                out_valid_r;
  logic [1:0]          out_ch_r;
  logic signed [63:0]  out_pos_r;
  logic signed [63:0]  out_vel_r;
  logic [1:0]          out_kind_r;
  logic signed [63:0]  out_avg_r;
  logic                out_last_r;

  // Control strobes.
  logic in_acc;
  logic in_ch_ok;
  logic out_free;
  logic out_load;
  logic mem_rd_en;
  logic mem_wr_en;
  logic cnt_last;
  logic div_start;
  logic mul_start;

  // Memory, divider and multiplier connections.
  logic [CH_W-1:0] mem_addr;
  ch_entry_t       ent;
  ch_entry_t       ev_entry;
  ch_entry_t       tk_entry;
  ch_entry_t       mem_wr_data;
  div_req_t        div_req;
  div_rsp_t        div_rsp;
  mul_req_t        mul_req;
  mul_rsp_t        mul_rsp;

  // Datapath helpers.
  logic [31:0]        chg_mag;
  logic [47:0]        inst_mag;
  logic [63:0]        sum_mag;
  logic signed [31:0] gain_sel;
  logic               avg_go;
  logic [64:0]        sum_ext;
  logic [15:0]        idle_inc;
  logic [1:0]         kind_nxt;

  assign in_acc   = in_bus.valid && in_bus.ready;
  assign in_ch_ok = 32'(in_bus.channel) < CHANNELS;
  assign out_free = !out_valid_r || out_bus.ready;
  assign cnt_last = (cnt_r == CH_W'(CHANNELS - 1));

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samples_len_r <= SAMPLES_LEN_RST;
      idle_ticks_r  <= IDLE_TICKS_RST;
      gain_r[0]     <= GAIN_CH0_RST;
      gain_r[1]     <= GAIN_ONE;
      gain_r[2]     <= GAIN_ONE;
      gain_r[3]     <= GAIN_ONE;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SAMPLES_LEN: samples_len_r <= cfg_wdata[15:0];
        REG_IDLE_TICKS:  idle_ticks_r  <= cfg_wdata[15:0];
        REG_GAIN_CH0:    gain_r[0]     <= $signed(cfg_wdata);
        REG_GAIN_CH1:    gain_r[1]     <= $signed(cfg_wdata);
        REG_GAIN_CH2:    gain_r[2]     <= $signed(cfg_wdata);
        REG_GAIN_CH3:    gain_r[3]     <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_bus.op == OP_TICK) begin
            state_nxt = ST_TK_RD;
          end else if (in_ch_ok) begin
            state_nxt = ST_EV_RD;
          end
        end
      end
      ST_EV_RD:    state_nxt = ST_EV_START;
      ST_EV_START: state_nxt = (iv_r == '0) ? ST_EV_SPD : ST_EV_DIV;
      ST_EV_DIV:   if (div_rsp.done) state_nxt = ST_EV_SPD;
      ST_EV_SPD:   state_nxt = ST_EV_WB;
      ST_EV_WB:    state_nxt = ST_IDLE;
      ST_TK_RD:    state_nxt = ST_TK_POS;
      ST_TK_POS:   state_nxt = ST_TK_VEL;
      ST_TK_VEL: begin
        if (mul_rsp.done) begin
          state_nxt = avg_go ? ST_TK_DIVS : ST_TK_OUT;
        end
      end
      ST_TK_DIVS:  state_nxt = ST_TK_DIV;
      ST_TK_DIV:   if (div_rsp.done) state_nxt = ST_TK_AMUL;
      ST_TK_AMUL:  state_nxt = ST_TK_AWAIT;
      ST_TK_AWAIT: if (mul_rsp.done) state_nxt = ST_TK_OUT;
      ST_TK_OUT: begin
        if (out_free) begin
          state_nxt = cnt_last ? ST_IDLE : ST_TK_RD;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_bus.ready = 1'b0;
    mem_rd_en    = 1'b0;
    mem_wr_en    = 1'b0;
    div_start    = 1'b0;
    mul_start    = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      ST_IDLE:     in_bus.ready = 1'b1;
      ST_EV_RD:    mem_rd_en    = 1'b1;
      ST_EV_START: div_start    = (iv_r != '0);
      ST_EV_WB:    mem_wr_en    = 1'b1;
      ST_TK_RD:    mem_rd_en    = 1'b1;
      ST_TK_POS:   mul_start    = 1'b1;
      ST_TK_DIVS:  div_start    = 1'b1;
      ST_TK_AMUL:  mul_start    = 1'b1;
      ST_TK_OUT: begin
        mem_wr_en = out_free;
        out_load  = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Channel counter of a tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc) begin
      cnt_r <= '0;
    end else if (out_load && !cnt_last) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Operand selection for the shared units.
  always_comb begin
    chg_mag  = chg_r[31] ? (~chg_r + 32'd1) : chg_r;
    inst_mag = ent.inst_speed[47] ? (~ent.inst_speed + 48'd1) : ent.inst_speed;
    sum_mag  = ent.speed_sum[63] ? (~ent.speed_sum + 64'd1) : ent.speed_sum;
    gain_sel = (32'(cnt_r) < NUM_GAINS) ? gain_r[2'(cnt_r)] : GAIN_ONE;
    avg_go   = (samples_len_r != '0) && ent.updated && (ent.sample_count >= samples_len_r);

    mul_req.start = mul_start;
    mul_req.gain  = gain_sel;
    if (state_r == ST_TK_AMUL) begin
      mul_req.mag   = div_rsp.quotient;
      mul_req.a_neg = ent.speed_sum[63];
    end else begin
      mul_req.mag   = 64'(inst_mag);
      mul_req.a_neg = ent.inst_speed[47];
    end

    div_req.start = div_start;
    if (state_r == ST_TK_DIVS) begin
      div_req.dividend = sum_mag;
      div_req.divisor  = DVS_W'(ent.sample_count);
    end else begin
      div_req.dividend = DVD_W'(prod_r);
      div_req.divisor  = iv_r;
    end
  end

  // Event speed, saturated to 48 bits; a zero interval gives zero for no change, else saturates by sign of the change.
  always_comb begin
    if (iv_r == '0) begin
      if (chg_r == '0) begin
        sp_nxt = '0;
      end else begin
        sp_nxt = chg_r[31] ? SPEED_MIN : SPEED_MAX;
      end
    end else if (chg_r[31]) begin
      sp_nxt = (div_rsp.quotient > 64'h0000_8000_0000_0000) ? SPEED_MIN :
               $signed(48'(~div_rsp.quotient + 64'd1));
    end else begin
      sp_nxt = (div_rsp.quotient > 64'(SPEED_MAX)) ? SPEED_MAX :
               $signed(div_rsp.quotient[47:0]);
    end
  end

  // Event write-back entry with saturating sum and sample count.
  always_comb begin
    sum_ext  = {ent.speed_sum[63], ent.speed_sum} + {{17{sp_r[47]}}, sp_r};
    ev_entry = ent;
    ev_entry.count_pos  = pos_r;
    ev_entry.inst_speed = sp_r;
    if (sum_ext[64] != sum_ext[63]) begin
      ev_entry.speed_sum = sum_ext[64] ? SUM_MIN : SUM_MAX;
    end else begin
      ev_entry.speed_sum = $signed(sum_ext[63:0]);
    end
    ev_entry.sample_count = (ent.sample_count == CNT_MAX) ? CNT_MAX :
                            ent.sample_count + 16'd1;
    ev_entry.updated    = 1'b1;
    ev_entry.idle_count = '0;
  end

  // Tick write-back entry and the average kind of the result.
  always_comb begin
    idle_inc = (ent.idle_count == CNT_MAX) ? CNT_MAX : ent.idle_count + 16'd1;
    tk_entry = ent;
    tk_entry.inst_speed = '0;
    tk_entry.updated    = 1'b0;
    kind_nxt = AVG_NONE;
    if (samples_len_r != '0) begin
      if (!ent.updated) begin
        tk_entry.idle_count = idle_inc;
        if (idle_inc >= idle_ticks_r) begin
          kind_nxt = AVG_IDLE;
        end
      end else begin
        tk_entry.idle_count = '0;
        if (avg_go) begin
          kind_nxt              = AVG_NEW;
          tk_entry.speed_sum    = '0;
          tk_entry.sample_count = '0;
        end
      end
    end
  end

  assign mem_addr    = (state_r == ST_EV_RD || state_r == ST_EV_WB) ? CH_W'(ch_r) : cnt_r;
  assign mem_wr_data = (state_r == ST_EV_WB) ? ev_entry : tk_entry;

  // Item latch and working registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r  <= in_bus.channel;
      pos_r <= in_bus.position;
      chg_r <= in_bus.position_change;
      iv_r  <= in_bus.interval_us;
    end
    if (state_r == ST_EV_RD) begin
      prod_r <= PROD_W'(chg_mag) * PROD_W'(SCALE_US_Q8);
    end
    if (state_r == ST_EV_SPD) begin
      sp_r <= sp_nxt;
    end
    if (state_r == ST_TK_POS) begin
      pos_rad_r <= ent.count_pos * gain_sel;
    end
    if (state_r == ST_TK_VEL && mul_rsp.done) begin
      vel_r <= mul_rsp.value;
    end
    if (state_r == ST_TK_AWAIT && mul_rsp.done) begin
      avg_r <= mul_rsp.value;
    end
  end

  // Output register: valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch_r   <= 2'(cnt_r);
      out_pos_r  <= pos_rad_r;
      out_vel_r  <= vel_r;
      out_kind_r <= kind_nxt;
      out_avg_r  <= (kind_nxt == AVG_NEW) ? avg_r : '0;
      out_last_r <= cnt_last;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.out_channel  = out_ch_r;
  assign out_bus.position_rad = out_pos_r;
  assign out_bus.velocity_rad = out_vel_r;
  assign out_bus.avg_kind     = out_kind_r;
  assign out_bus.avg_speed    = out_avg_r;
  assign out_bus.last         = out_last_r;

  esd_mem #(
    .CHANNELS (CHANNELS)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_addr),
    .rd_data (ent),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_addr),
    .wr_data (mem_wr_data)
  );

  esd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  esd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  // The memory is never read and written back in the same cycle.
  a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_rd_en && mem_wr_en))
    else $error("channel memory read and write in the same cycle");

  // The divider is never started with a zero divisor.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (div_req.divisor != '0))
    else $error("divider started with zero divisor");

  // A tick starts its sweep at channel zero.
  a_tick_starts_ch0: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_bus.op == OP_TICK) |=> (state_r == ST_TK_RD && cnt_r == '0))
    else $error("tick sweep did not start at channel zero");

  // The position step of a tick always follows a read of the channel memory.
  a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TK_POS) |-> $past(mem_rd_en))
    else $error("tick channel used without a memory read");

endmodule
